@@ rtl/core/dtfl_pkg.sv @@
// ----------------------------------------------------------------------------
// dtfl_pkg: shared types and constants of the descriptor table free list
// Operation codes, flag bits, the table write request and the
// increment/compare unit interface.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfl_pkg;

  localparam int QSW = 9;

  localparam logic [QSW-1:0] QS_RESET = 9'd256;
  localparam logic [QSW-1:0] QS_MIN   = 9'd2;

  localparam logic [2:0] OP_INIT          = 3'd0;
  localparam logic [2:0] OP_ALLOC         = 3'd1;
  localparam logic [2:0] OP_FREE          = 3'd2;
  localparam logic [2:0] OP_RELEASE_CHAIN = 3'd3;
  localparam logic [2:0] OP_WRITE_DESC    = 3'd4;
  localparam logic [2:0] OP_LINK_DESC     = 3'd5;

  localparam logic [15:0] FLAG_NEXT = 16'h0001;
  localparam logic [15:0] END_MARK  = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        we_link;
    logic        we_flags;
    logic        we_data;
    logic [15:0] link;
    logic [15:0] flags;
    logic [63:0] addr;
    logic [31:0] len;
  } tbl_wr_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] lim;
    logic        dec;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] res;
    logic        b_lt;
    logic        c_lt;
  } alu_out_t;

endpackage

`default_nettype wire

@@ rtl/core/dtfl_alu.sv @@
// ----------------------------------------------------------------------------
// dtfl_alu: shared increment and range compare unit
// Steps one operand up (saturating) or down, and checks two operands
// against the active queue size.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfl_alu (
  input  dtfl_pkg::alu_in_t  alu_in,
  output dtfl_pkg::alu_out_t alu_out
);
  import dtfl_pkg::*;

  always_comb begin
    if (alu_in.dec) begin
      alu_out.res = alu_in.a - 16'd1;
    end else if (alu_in.a == COUNT_MAX) begin
      alu_out.res = alu_in.a;
    end else begin
      alu_out.res = alu_in.a + 16'd1;
    end
    alu_out.b_lt = (alu_in.b < alu_in.lim);
    alu_out.c_lt = (alu_in.c < alu_in.lim);
  end

endmodule

`default_nettype wire

@@ rtl/core/dtfl_table.sv @@
// ----------------------------------------------------------------------------
// dtfl_table: descriptor entry storage
// Link, flags and buffer fields in separate memories, one write port each
// sharing a write address, one registered read port for link and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfl_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  dtfl_pkg::tbl_wr_t wr,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     raddr,
  output logic [15:0]       rd_link,
  output logic [15:0]       rd_flags
);
  import dtfl_pkg::*;

  logic [15:0] link_mem  [DEPTH];
  logic [15:0] flags_mem [DEPTH];
  logic [95:0] data_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_link) begin
      link_mem[waddr] <= wr.link;
    end
    if (wr.we_flags) begin
      flags_mem[waddr] <= wr.flags;
    end
    if (wr.we_data) begin
      data_mem[waddr] <= {wr.addr, wr.len};
    end
    rd_link  <= link_mem[raddr];
    rd_flags <= flags_mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/descriptor_table_free_list.sv @@
// ----------------------------------------------------------------------------
// descriptor_table_free_list: descriptor table with a threaded free list
// Sequencer over the entry table and a shared increment/compare unit.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                                       Handshake
// command   in         op index buf_addr buf_len desc_flags_in       start & !busy
//                      link_index
// result    out        got_index ok free_left                        done strobe
// config    in         cfg_wr_data (entry count in use)              cfg_wr_en
//
// Sequence: alloc, free, descriptor write, link and unknown codes are accepted,
//   then do at most one table write, the entry read being prefetched through the
//   single registered read port. init_list writes the n entries in turn. A chain
//   free does one table read then write per freed entry, then gives the result,
//   and stops after an entry without NEXT, after n entries, or at an index
//   out of range; n is the size register clamped to 2..DEPTH.
// Reset: synchronous; the free count and head clear and the size register
//   goes to 256. Entry contents stay undefined until written; there is no
//   clear pass.
// Stalls: the receiver cannot stall; done is high for one cycle per item and
//   busy is low again in that same cycle, so a new item may be taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_table_free_list #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [15:0] index,
  input  logic [63:0] buf_addr,
  input  logic [31:0] buf_len,
  input  logic [15:0] desc_flags_in,
  input  logic [15:0] link_index,
  input  logic        cfg_wr_en,
  input  logic [dtfl_pkg::QSW-1:0] cfg_wr_data,
  output logic        done,
  output logic [15:0] got_index,
  output logic        ok,
  output logic [15:0] free_left
);
  import dtfl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_INIT     = 5'b00010,
    S_EXEC     = 5'b00100,
    S_CHAIN_RD = 5'b01000,
    S_CHAIN_WR = 5'b10000
  } state_t;

  state_t         state, state_next;
  logic [QSW-1:0] size_cfg;
  logic [QSW-1:0] n_act;
  logic [15:0]    n_ext;

  logic [15:0]    list_head, list_head_next;
  logic [15:0]    free_total, free_total_next;

  // latched command
  logic [2:0]     op_r;
  logic [15:0]    idx_r;
  logic [63:0]    addr_r;
  logic [31:0]    len_r;
  logic [15:0]    flg_r;
  logic [15:0]    link_r;

  logic [15:0]    cur, cur_next;
  logic [QSW-1:0] cnt, cnt_next;
  logic [QSW-1:0] cnt_inc;

  logic           emit;
  logic           emit_ok;
  logic [15:0]    emit_got;

  tbl_wr_t        wr;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;
  logic [15:0]    rd_link;
  logic [15:0]    rd_flags;

  alu_in_t        alu_in;
  alu_out_t       alu_out;

  logic           accept;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign cnt_inc = cnt + QSW'(1);

  // active queue size, clamped to 2..DEPTH
  always_comb begin
    if (size_cfg < QS_MIN) begin
      n_act = QS_MIN;
    end else if (int'(size_cfg) > DEPTH) begin
      n_act = QSW'(DEPTH);
    end else begin
      n_act = size_cfg;
    end
    n_ext = {{(16-QSW){1'b0}}, n_act};
  end

  dtfl_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  dtfl_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .wr       (wr),
    .waddr    (waddr),
    .raddr    (raddr),
    .rd_link  (rd_link),
    .rd_flags (rd_flags)
  );

  // read address: while idle, prefetch the entry the next item needs
  always_comb begin
    if (state == S_IDLE) begin
      raddr = (op == OP_ALLOC) ? AW'(list_head) : AW'(index);
    end else begin
      raddr = AW'(cur);
    end
  end

  always_comb begin
    state_next      = state;
    list_head_next  = list_head;
    free_total_next = free_total;
    cur_next        = cur;
    cnt_next        = cnt;
    emit            = 1'b0;
    emit_ok         = 1'b0;
    emit_got        = 16'd0;

    wr       = '0;
    waddr    = AW'(idx_r);

    alu_in     = '0;
    alu_in.a   = free_total;
    alu_in.lim = n_ext;
    alu_in.b   = idx_r;
    alu_in.c   = link_r;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          cur_next = index;
          case (op)
            OP_INIT:          state_next = S_INIT;
            OP_RELEASE_CHAIN: state_next = S_CHAIN_RD;
            default:          state_next = S_EXEC;
          endcase
        end
      end

      S_INIT: begin
        // sweep: link each entry to the following one, last gets the end mark
        alu_in.a   = {{(16-QSW){1'b0}}, cnt};
        alu_in.b   = {{(16-QSW){1'b0}}, cnt_inc};
        waddr      = AW'(cnt);
        wr.we_link  = 1'b1;
        wr.we_flags = 1'b1;
        if (alu_out.b_lt) begin
          wr.link  = alu_out.res;
          wr.flags = FLAG_NEXT;
          cnt_next = alu_out.res[QSW-1:0];
        end else begin
          wr.link         = END_MARK;
          wr.flags        = '0;
          list_head_next  = 16'd0;
          free_total_next = n_ext;
          emit            = 1'b1;
          emit_ok         = 1'b1;
          state_next      = S_IDLE;
        end
      end

      S_EXEC: begin
        emit       = 1'b1;
        state_next = S_IDLE;
        case (op_r)
          OP_ALLOC: begin
            alu_in.b   = list_head;
            alu_in.dec = 1'b1;
            waddr      = AW'(list_head);
            if (free_total != 16'd0 && alu_out.b_lt) begin
              wr.we_link      = 1'b1;
              wr.we_flags     = 1'b1;
              wr.we_data      = 1'b1;
              list_head_next  = rd_link;
              free_total_next = alu_out.res;
              emit_got        = list_head;
              emit_ok         = 1'b1;
            end
          end
          OP_FREE: begin
            if (alu_out.b_lt) begin
              wr.we_link      = 1'b1;
              wr.we_flags     = 1'b1;
              wr.link         = list_head;
              wr.flags        = FLAG_NEXT;
              list_head_next  = idx_r;
              free_total_next = alu_out.res;
              emit_ok         = 1'b1;
            end
          end
          OP_WRITE_DESC: begin
            if (alu_out.b_lt) begin
              wr.we_flags = 1'b1;
              wr.we_data  = 1'b1;
              wr.flags    = flg_r;
              wr.addr     = addr_r;
              wr.len      = len_r;
              emit_ok     = 1'b1;
            end
          end
          OP_LINK_DESC: begin
            if (alu_out.b_lt && alu_out.c_lt) begin
              wr.we_link  = 1'b1;
              wr.we_flags = 1'b1;
              wr.link     = link_r;
              wr.flags    = rd_flags | FLAG_NEXT;
              emit_ok     = 1'b1;
            end
          end
          default: begin
            emit_ok = 1'b0;
          end
        endcase
      end

      S_CHAIN_RD: begin
        // check range, read the entry's flags and link
        alu_in.b = cur;
        if (alu_out.b_lt) begin
          state_next = S_CHAIN_WR;
        end else begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_CHAIN_WR: begin
        // push the current entry, then follow its link while NEXT was set and the freed count is below the queue size
        alu_in.c        = {{(16-QSW){1'b0}}, cnt_inc};
        waddr           = AW'(cur);
        wr.we_link      = 1'b1;
        wr.we_flags     = 1'b1;
        wr.link         = list_head;
        wr.flags        = FLAG_NEXT;
        list_head_next  = cur;
        free_total_next = alu_out.res;
        cnt_next        = cnt_inc;
        if (rd_flags[0] && alu_out.c_lt) begin
          cur_next   = rd_link;
          state_next = S_CHAIN_RD;
        end else begin
          emit       = 1'b1;
          emit_ok    = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      size_cfg   <= QS_RESET;
      list_head  <= 16'd0;
      free_total <= 16'd0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      list_head  <= list_head_next;
      free_total <= free_total_next;
      done       <= emit;
      if (cfg_wr_en) begin
        size_cfg <= cfg_wr_data;
      end
    end
  end

  // payload registers: hold the command, advance the walk, drive the result
  always_ff @(posedge clk) begin
    cur <= cur_next;
    cnt <= cnt_next;
    if (accept) begin
      op_r   <= op;
      idx_r  <= index;
      addr_r <= buf_addr;
      len_r  <= buf_len;
      flg_r  <= desc_flags_in;
      link_r <= link_index;
    end
    if (emit) begin
      got_index <= emit_got;
      ok        <= emit_ok;
      free_left <= free_total_next;
    end
  end

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_got_only_on_ok : assert property (@(posedge clk) disable iff (rst)
    (done && got_index != 16'd0) |-> ok)
    else $error("nonzero index handed out on a failed operation");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not start work");

  a_free_left_tracks : assert property (@(posedge clk) disable iff (rst)
    done |-> (free_left == free_total))
    else $error("reported free count differs from the stored count");

endmodule

`default_nettype wire

@@ verif/descriptor_table_free_list_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// descriptor_table_free_list_tb: self-checking bench for the descriptor table
// Drives command items through the start/busy handshake and predicts every
// result with a shadow copy of the table, the free list and the size register.
// Each result is compared field by field, in order. Stimulus runs a directed
// sweep, then random phases at several queue sizes, then a saturation pass.
// ----------------------------------------------------------------------------
module descriptor_table_free_list_tb;
  import dtfl_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int SETTLE_CYCLES = 20;
  // Slowest item is a full-length chain free, one read and one write per entry,
  // plus the longest sender gap; keep a wide margin above that.
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 48;

  // Codes the block does not define; it must answer them with ok 0.
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam logic [QSW-1:0] PHASE_SIZES [9] = '{
    9'd256, 9'd2, 9'd0, 9'd3, 9'd16, 9'd511, 9'd1, 9'd300, 9'd40
  };

  typedef struct packed {
    logic [15:0] got;
    logic        ok;
    logic [15:0] left;
  } answer_t;

  // Shadow of the descriptor table and free list. Each accepted item is
  // applied here and the answer it must produce is queued.
  class desc_table_shadow;
    logic [63:0]    entry_addr  [TABLE_DEPTH];
    logic [31:0]    entry_len   [TABLE_DEPTH];
    logic [15:0]    entry_flags [TABLE_DEPTH];
    logic [15:0]    entry_link  [TABLE_DEPTH];
    logic [15:0]    list_head = '0;
    logic [15:0]    free_total = '0;
    logic [QSW-1:0] size_cfg = QS_RESET;
    logic           last_alloc_ok = 1'b0;
    logic [15:0]    last_alloc_index = '0;
    int unsigned    fails = 0;
    answer_t        answers_due [$];

    function int unsigned in_use();
      if (size_cfg < QS_MIN) return QS_MIN;
      if (size_cfg > TABLE_DEPTH) return TABLE_DEPTH;
      return size_cfg;
    endfunction

    function void push_free(logic [15:0] at);
      entry_link[at] = list_head;
      entry_flags[at] = FLAG_NEXT;
      list_head = at;
      if (free_total < COUNT_MAX) free_total++;
    endfunction

    function void take_command(logic [2:0] code, logic [15:0] idx, logic [63:0] addr_in,
                               logic [31:0] len_in, logic [15:0] flags_in,
                               logic [15:0] link_in);
      int unsigned n;
      int unsigned cur;
      int unsigned steps;
      logic [15:0] seen_flags;
      logic [15:0] seen_link;
      answer_t ans;
      n = in_use();
      ans = '0;
      last_alloc_ok = 1'b0;
      case (code)
        OP_INIT: begin
          for (int i = 0; i + 1 < n; i++) begin
            entry_link[i] = 16'(i + 1);
            entry_flags[i] = FLAG_NEXT;
          end
          entry_link[n - 1] = END_MARK;
          entry_flags[n - 1] = '0;
          list_head = '0;
          free_total = 16'(n);
          ans.ok = 1'b1;
        end
        OP_ALLOC: begin
          if (free_total != 0 && list_head < n) begin
            ans.got = list_head;
            list_head = entry_link[ans.got];
            free_total--;
            entry_addr[ans.got] = '0;
            entry_len[ans.got] = '0;
            entry_flags[ans.got] = '0;
            entry_link[ans.got] = '0;
            ans.ok = 1'b1;
            last_alloc_ok = 1'b1;
            last_alloc_index = ans.got;
          end
        end
        OP_FREE: begin
          if (idx < n) begin
            push_free(idx);
            ans.ok = 1'b1;
          end
        end
        OP_RELEASE_CHAIN: begin
          cur = idx;
          steps = 0;
          ans.ok = 1'b1;
          while (steps < n) begin
            if (cur >= n) begin
              ans.ok = 1'b0;
              break;
            end
            seen_flags = entry_flags[cur];
            seen_link = entry_link[cur];
            push_free(16'(cur));
            steps++;
            if ((seen_flags & FLAG_NEXT) == 0) break;
            cur = seen_link;
          end
        end
        OP_WRITE_DESC: begin
          if (idx < n) begin
            entry_addr[idx] = addr_in;
            entry_len[idx] = len_in;
            entry_flags[idx] = flags_in;
            ans.ok = 1'b1;
          end
        end
        OP_LINK_DESC: begin
          if (idx < n && link_in < n) begin
            entry_link[idx] = link_in;
            entry_flags[idx] = entry_flags[idx] | FLAG_NEXT;
            ans.ok = 1'b1;
          end
        end
        default: ;
      endcase
      ans.left = free_total;
      answers_due.push_back(ans);
    endfunction

    function void match_answer(logic [15:0] got, logic okv, logic [15:0] left);
      answer_t want;
      if (answers_due.size() == 0) begin
        $error("result with no item outstanding: got_index %0d ok %0d free_left %0d",
               got, okv, left);
        fails++;
        return;
      end
      want = answers_due.pop_front();
      if (got !== want.got) begin
        $error("got_index: expected %0d, actual %0d", want.got, got);
        fails++;
      end
      if (okv !== want.ok) begin
        $error("ok: expected %0d, actual %0d", want.ok, okv);
        fails++;
      end
      if (left !== want.left) begin
        $error("free_left: expected %0d, actual %0d", want.left, left);
        fails++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  logic [2:0]     op;
  logic [15:0]    index;
  logic [63:0]    buf_addr;
  logic [31:0]    buf_len;
  logic [15:0]    desc_flags_in;
  logic [15:0]    link_index;
  logic           cfg_wr_en;
  logic [QSW-1:0] cfg_wr_data;
  logic           done;
  logic [15:0]    got_index;
  logic           ok;
  logic [15:0]    free_left;

  desc_table_shadow shadow = new();
  int unsigned items_sent;
  int          burst_left;
  int unsigned quiet_cycles;

  descriptor_table_free_list #(
    .DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .index(index),
    .buf_addr(buf_addr),
    .buf_len(buf_len),
    .desc_flags_in(desc_flags_in),
    .link_index(link_index),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .done(done),
    .got_index(got_index),
    .ok(ok),
    .free_left(free_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every result strobe against the oldest prediction. The watchdog
  // counts cycles in which neither an item nor a result moves; a hung block
  // ends the run here.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) shadow.match_answer(got_index, ok, free_left);
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly in range, with the boundary, the end mark and wild values mixed in.
  function automatic logic [15:0] pick_index(int unsigned n);
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return 16'($urandom_range(0, n - 1));
    if (r == 16) return 16'(n);
    if (r == 17) return 16'hFFFF;
    return 16'($urandom_range(n, 16'hFFFF));
  endfunction

  // Present one item, hold it until accepted, then record the prediction.
  // Start stays high across a burst; drop it for a random gap between bursts.
  task automatic drive_item(logic [2:0] code, logic [15:0] idx, logic [63:0] addr_v,
                            logic [31:0] len_v, logic [15:0] flags_v,
                            logic [15:0] link_v);
    start <= 1'b1;
    op <= code;
    index <= idx;
    buf_addr <= addr_v;
    buf_len <= len_v;
    desc_flags_in <= flags_v;
    link_index <= link_v;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.take_command(code, idx, addr_v, len_v, flags_v, link_v);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Same, with random buffer address, length and flags.
  task automatic command(logic [2:0] code, logic [15:0] idx, logic [15:0] link_v);
    drive_item(code, idx, rnd64(), $urandom, 16'($urandom), link_v);
  endtask

  // Hold off until every prediction is answered, then let the block go quiet.
  task automatic settle();
    start <= 1'b0;
    while (shadow.answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the size register only with the block idle.
  task automatic set_size_cfg(logic [QSW-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.size_cfg = v;
  endtask

  // A well-formed descriptor life cycle: allocate a few entries, fill them,
  // link them into a chain with NEXT on all but the tail, then mostly give them back.
  task automatic chain_round();
    logic [15:0] taken [4];
    logic [15:0] fl;
    int cnt;
    int k;
    int r;
    cnt = 0;
    k = $urandom_range(1, 4);
    for (int j = 0; j < k; j++) begin
      command(OP_ALLOC, 16'($urandom), 16'($urandom));
      if (shadow.last_alloc_ok) begin
        taken[cnt] = shadow.last_alloc_index;
        cnt++;
      end
    end
    for (int j = 0; j < cnt; j++) begin
      fl = 16'($urandom);
      fl[0] = (j < cnt - 1);
      drive_item(OP_WRITE_DESC, taken[j], rnd64(), $urandom, fl, 16'($urandom));
    end
    for (int j = 0; j + 1 < cnt; j++) command(OP_LINK_DESC, taken[j], taken[j + 1]);
    r = $urandom_range(0, 9);
    if (cnt > 0 && r < 7) begin
      command(OP_RELEASE_CHAIN, taken[0], 16'($urandom));
    end else if (r < 9) begin
      for (int j = 0; j < cnt; j++) command(OP_FREE, taken[j], 16'($urandom));
    end
  endtask

  // Any operation with loosely aimed indexes, including undefined codes.
  task automatic random_command(int unsigned n);
    logic [2:0] code;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) code = OP_INIT;
    else if (r < 30) code = OP_ALLOC;
    else if (r < 52) code = OP_FREE;
    else if (r < 62) code = OP_RELEASE_CHAIN;
    else if (r < 77) code = OP_WRITE_DESC;
    else if (r < 94) code = OP_LINK_DESC;
    else if (r < 97) code = OP_RSVD6;
    else code = OP_RSVD7;
    drive_item(code, pick_index(n), rnd64(), $urandom, 16'($urandom), pick_index(n));
  endtask

  initial begin
    int unsigned n;
    int unsigned target;
    int guard;
    rst = 1'b1;
    start = 1'b0;
    op = OP_INIT;
    index = '0;
    buf_addr = '0;
    buf_len = '0;
    desc_flags_in = '0;
    link_index = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = QS_RESET;
    items_sent = 0;
    burst_left = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed sweep. Build the full list first so every entry that a later
    // alloc or chain walk reads has been written.
    command(OP_INIT, 16'h0000, 16'h0000);
    command(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    drive_item(OP_WRITE_DESC, 16'd1, '1, '1, 16'hFFFF, 16'h0000);
    drive_item(OP_WRITE_DESC, 16'd5, '0, '0, 16'h0000, 16'hFFFF);
    command(OP_WRITE_DESC, 16'd256, 16'd0);
    command(OP_LINK_DESC, 16'd1, 16'd255);
    command(OP_LINK_DESC, 16'd1, 16'hFFFF);
    command(OP_LINK_DESC, 16'd300, 16'd1);
    command(OP_FREE, 16'd0, 16'd0);
    command(OP_FREE, 16'hFFFF, 16'd0);
    command(OP_RSVD6, 16'd3, 16'd4);
    command(OP_RSVD7, 16'd3, 16'd4);
    command(OP_RELEASE_CHAIN, 16'hFFFF, 16'd0);
    command(OP_FREE, 16'd200, 16'd0);

    // Shrink under a head left from the larger size: alloc must refuse it,
    // and a chain that walks past the new size stops with ok 0.
    set_size_cfg(9'd4);
    command(OP_ALLOC, 16'd0, 16'd0);
    command(OP_RELEASE_CHAIN, 16'd2, 16'd0);

    // Size below the minimum acts as two; drain the list to empty.
    set_size_cfg(9'd0);
    command(OP_INIT, 16'd0, 16'd0);
    repeat (3) command(OP_ALLOC, 16'd0, 16'd0);

    // Two-entry cycle: the walk must stop after n entries with ok 1.
    set_size_cfg(9'd1);
    command(OP_INIT, 16'd0, 16'd0);
    command(OP_LINK_DESC, 16'd1, 16'd0);
    command(OP_RELEASE_CHAIN, 16'd0, 16'd0);

    // Size above the table acts as the table; steer the head onto the end
    // mark while the count is still nonzero, so alloc refuses it.
    set_size_cfg(9'd511);
    command(OP_INIT, 16'd0, 16'd0);
    command(OP_LINK_DESC, 16'd0, 16'(TABLE_DEPTH - 1));
    repeat (3) command(OP_ALLOC, 16'd0, 16'd0);

    // Random phases, each at its own queue size and starting from a fresh
    // list. Mostly allocate/fill/link/free cycles, the rest loose commands.
    for (int p = 0; p < 9; p++) begin
      if (p == 8) set_size_cfg(9'($urandom_range(4, 64)));
      else set_size_cfg(PHASE_SIZES[p]);
      n = shadow.in_use();
      command(OP_INIT, 16'($urandom), 16'($urandom));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(0, 39) == 0) settle();
        if ($urandom_range(0, 9) < 6) chain_round();
        else random_command(n);
      end
    end

    // Drive the free count into saturation: close the full list into a ring,
    // then free along it until the count pins at its maximum. Frees past that
    // must hold it there; one alloc steps it back down.
    set_size_cfg(QS_RESET);
    command(OP_INIT, 16'd0, 16'd0);
    command(OP_LINK_DESC, 16'(TABLE_DEPTH - 1), 16'd0);
    guard = 0;
    while (shadow.free_total != COUNT_MAX && guard < 400) begin
      command(OP_RELEASE_CHAIN, 16'($urandom_range(0, TABLE_DEPTH - 1)), 16'd0);
      guard++;
    end
    repeat (2) command(OP_FREE, 16'($urandom_range(0, TABLE_DEPTH - 1)), 16'd0);
    command(OP_ALLOC, 16'd0, 16'd0);

    settle();
    if (shadow.fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ descriptor_table_free_list.f @@
rtl/core/dtfl_pkg.sv
rtl/core/dtfl_alu.sv
rtl/core/dtfl_table.sv
rtl/core/descriptor_table_free_list.sv
verif/descriptor_table_free_list_tb.sv
